[rtl/tes_pkg.sv]
// Shared constants and types for the two-ended shared stack.
`default_nettype none

package tes_pkg;

    localparam int DEPTH      = 256;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Fixed widths of the interface fields.
    localparam int MODE_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 9;

    localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
    } mem_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    length;
        logic                empty;
        logic                has_data;
    } op_result_t;

endpackage

`default_nettype wire

[rtl/tes_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module tes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/tes_ptr.sv]
// Stack length counters, full and empty checks, and memory address generation.
`default_nettype none

module tes_ptr
    import tes_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [MODE_W-1:0] mode,
    input  wire logic              which_stack,
    output mem_req_t               mem_req,
    output op_result_t             op_res
);

    logic [CNT_W-1:0] low_cnt_reg, low_cnt_next;
    logic [CNT_W-1:0] high_cnt_reg, high_cnt_next;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] new_cnt;
    logic [CNT_W-1:0] elem_idx;
    logic [CNT_W:0]   total;
    logic             full;
    logic             wr_req;
    logic             rd_req;
    logic [STATUS_W-1:0] status;

    assign cnt   = which_stack ? high_cnt_reg : low_cnt_reg;
    assign total = {1'b0, low_cnt_reg} + {1'b0, high_cnt_reg};
    assign full  = (total >= (CNT_W + 1)'(DEPTH));

    always_comb
    begin
        wr_req   = 1'b0;
        rd_req   = 1'b0;
        status   = STATUS_OK;
        new_cnt  = cnt;
        elem_idx = cnt;
        unique case (mode)
            MODE_PUSH:
            begin
                if (full)
                begin
                    status = STATUS_FULL;
                end
                else
                begin
                    wr_req  = 1'b1;
                    new_cnt = cnt + 1'b1;
                end
            end
            MODE_POP, MODE_PEEK:
            begin
                elem_idx = cnt - 1'b1;
                if (cnt == '0)
                begin
                    status = STATUS_EMPTY;
                end
                else
                begin
                    rd_req = 1'b1;
                    if (mode == MODE_POP)
                    begin
                        new_cnt = cnt - 1'b1;
                    end
                end
            end
            MODE_CLEAR:
            begin
                new_cnt = '0;
            end
            default:
            begin
                new_cnt = cnt;
            end
        endcase
    end

    // The high stack places element k at the top entry minus k.
    always_comb
    begin
        mem_req.wr_en = accept && wr_req;
        mem_req.rd_en = accept && rd_req;
        if (which_stack)
        begin
            mem_req.addr = ADDR_W'(DEPTH - 1) - elem_idx[ADDR_W-1:0];
        end
        else
        begin
            mem_req.addr = elem_idx[ADDR_W-1:0];
        end
    end

    assign op_res.status   = status;
    assign op_res.length   = new_cnt;
    assign op_res.empty    = (new_cnt == '0);
    assign op_res.has_data = rd_req;

    always_comb
    begin
        low_cnt_next  = low_cnt_reg;
        high_cnt_next = high_cnt_reg;
        if (accept)
        begin
            if (which_stack)
            begin
                high_cnt_next = new_cnt;
            end
            else
            begin
                low_cnt_next = new_cnt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_cnt_reg  <= '0;
            high_cnt_reg <= '0;
        end
        else
        begin
            low_cnt_reg  <= low_cnt_next;
            high_cnt_reg <= high_cnt_next;
        end
    end

endmodule

`default_nettype wire

[rtl/two_ended_shared_stack_core.sv]
// Top level of the two-ended shared stack: request decode, element memory and result stage.
`default_nettype none

// Two LIFO stacks share one 256-entry memory: the low stack grows up from entry 0 and the
// high stack grows down from the last entry. Each request pushes, pops, peeks or clears one
// stack and gives exactly one result, presented right after the accepting clock edge and
// taken at the next edge at the earliest: the counters and the memory access are handled in
// the accept cycle, and the result register holds status and length while the memory's
// registered read port supplies the element.
// A new request is taken every cycle as long as the result side takes each result; while a
// result waits, in_ready is low. No clearing pass is needed after reset.
module two_ended_shared_stack_core
    import tes_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [MODE_W-1:0]   mode,
    input  wire logic                which_stack,
    input  wire logic [VALUE_W-1:0]  push_value,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [VALUE_W-1:0]       read_value,
    output logic [STATUS_W-1:0]      result_status,
    output logic [LEN_W-1:0]         stack_length,
    output logic                     stack_empty
);

    logic                  accept;
    mem_req_t              mem_req;
    op_result_t            op_res;
    logic [DATA_WIDTH-1:0] rd_data;
    logic                  out_valid_reg, out_valid_next;
    op_result_t            res_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    tes_ptr u_ptr (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (mode),
        .which_stack (which_stack),
        .mem_req     (mem_req),
        .op_res      (op_res)
    );

    // Read data is only refreshed on an accepted request, so it holds while a result stalls.
    tes_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.addr),
        .wr_data (push_value[DATA_WIDTH-1:0]),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= op_res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_value    = res_reg.has_data ? VALUE_W'(rd_data) : '0;
    assign result_status = res_reg.status;
    assign stack_length  = LEN_W'(res_reg.length);
    assign stack_empty   = res_reg.empty;

endmodule

`default_nettype wire

[rtl/tes_checker.sv]
// Port-level assertions for the two-ended shared stack, bound to the top level.
`default_nettype none

module tes_checker
    import tes_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic [VALUE_W-1:0]  read_value,
    input wire logic [STATUS_W-1:0] result_status,
    input wire logic [LEN_W-1:0]    stack_length,
    input wire logic                stack_empty
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_value)
            && $stable(result_status) && $stable(stack_length))
        else $error("result changed while stalled");

    // Every accepted request yields a result on the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted request produced no result");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (stack_empty == (stack_length == '0)))
        else $error("empty flag disagrees with length");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_status != STATUS_OK |-> read_value == '0)
        else $error("refused request returned data");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_status == STATUS_EMPTY |-> stack_empty)
        else $error("empty status on a non-empty stack");

endmodule

bind two_ended_shared_stack_core tes_checker u_tes_checker (.*);

`default_nettype wire
